@@ hdl/fm_tone_generator_macros.svh @@
// Assertion macros for the fm_tone_generator block.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef FM_TONE_GENERATOR_MACROS_SVH
`define FM_TONE_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define FMTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

// Next-cycle implication.
`define FMTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);

`endif

@@ hdl/fmtg_pkg.sv @@
// Shared types, constants and the sine table generator for the FM tone block.
// No dependencies.
`timescale 1ns / 1ps

package fmtg_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAG_W     = 15;   // quarter-wave table entry
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 16;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DEV_SHIFT = 39;   // Q8.24 index times Q0.15 sine
  localparam int unsigned STEP_W    = 32;   // steps are in 2^32 units per turn
  localparam logic [63:0] PI_Q30    = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE    = 3'd0,
    REG_CARRIER_STEP = 3'd1,
    REG_MOD_STEP     = 3'd2,
    REG_MOD_INDEX    = 3'd3,
    REG_RUN_LENGTH   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSIN,   // modulator sine lookup
    ST_MMUL,   // index times modulator sine
    ST_CSUM,   // carrier phase plus deviation
    ST_CSIN,   // carrier sine lookup
    ST_CMUL,   // amplitude times carrier sine
    ST_OUT     // round, clamp, load output beat
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic rom_en;
    logic rom_car;
    logic mul_car;
    logic sum_load;
    logic out_load;
  } ctrl_t;

  // round(32767*sin(pi/2*k/2^abits)) through a Q30 Taylor series.
  // Only evaluated at elaboration to build the table.
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int unsigned        n;
    x    = (PI_Q30 * 64'(k)) >> (abits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

@@ hdl/fmtg_sine_rom.sv @@
// Quarter-wave sine lookup with quadrant folding and registered read.
// Depends on fmtg_pkg (table generator).
`timescale 1ns / 1ps

module fmtg_sine_rom #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned ADDR_BITS  = 10
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [PHASE_BITS-1:0]      phase,
  output logic [fmtg_pkg::MAG_W-1:0] mag,
  output logic                       neg
);

  localparam int unsigned ROM_N = 1 << ADDR_BITS;

  logic [fmtg_pkg::MAG_W-1:0] rom_tbl [0:ROM_N];
  logic [ADDR_BITS+1:0]       idx;
  logic [ADDR_BITS:0]         addr;

  for (genvar k = 0; k <= ROM_N; k++) begin : g_tbl
    localparam logic [fmtg_pkg::MAG_W-1:0] VAL = fmtg_pkg::sine_entry(k, ADDR_BITS);
    assign rom_tbl[k] = VAL;
  end

  assign idx = phase[PHASE_BITS-1 -: ADDR_BITS+2];

  // odd quadrants run the table backwards
  always_comb begin
    if (idx[ADDR_BITS]) begin
      addr = (ADDR_BITS+1)'(ROM_N) - {1'b0, idx[ADDR_BITS-1:0]};
    end else begin
      addr = {1'b0, idx[ADDR_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= rom_tbl[addr];
      neg <= idx[ADDR_BITS+1];
    end
  end

endmodule

@@ hdl/fmtg_mul.sv @@
// Shared unsigned multiplier with registered product.
// Depends on fmtg_pkg (operand widths).
`timescale 1ns / 1ps

module fmtg_mul (
  input  logic                         clk,
  input  logic [fmtg_pkg::MUL_A_W-1:0] a,
  input  logic [fmtg_pkg::MUL_B_W-1:0] b,
  output logic [fmtg_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= fmtg_pkg::PROD_W'(a) * fmtg_pkg::PROD_W'(b);
  end

endmodule

@@ hdl/fmtg_seq.sv @@
// Sample sequencer: steps one sample through lookup, multiply, sum and output.
// Depends on fmtg_pkg (state and control types) and the assertion macros.
`timescale 1ns / 1ps
`include "fm_tone_generator_macros.svh"

module fmtg_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            run_done,
  input  logic            out_free,
  output fmtg_pkg::ctrl_t ctrl
);

  fmtg_pkg::state_t state;
  fmtg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmtg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fmtg_pkg::ST_IDLE: begin
        if (in_valid && !run_done) state_next = fmtg_pkg::ST_MSIN;
      end
      fmtg_pkg::ST_MSIN: state_next = fmtg_pkg::ST_MMUL;
      fmtg_pkg::ST_MMUL: state_next = fmtg_pkg::ST_CSUM;
      fmtg_pkg::ST_CSUM: state_next = fmtg_pkg::ST_CSIN;
      fmtg_pkg::ST_CSIN: state_next = fmtg_pkg::ST_CMUL;
      fmtg_pkg::ST_CMUL: state_next = fmtg_pkg::ST_OUT;
      fmtg_pkg::ST_OUT: begin
        if (out_free) state_next = fmtg_pkg::ST_IDLE;
      end
      default: state_next = fmtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      fmtg_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      fmtg_pkg::ST_MSIN: ctrl.rom_en = 1'b1;
      fmtg_pkg::ST_MMUL: ctrl.mul_car = 1'b0;
      fmtg_pkg::ST_CSUM: ctrl.sum_load = 1'b1;
      fmtg_pkg::ST_CSIN: begin
        ctrl.rom_en  = 1'b1;
        ctrl.rom_car = 1'b1;
      end
      fmtg_pkg::ST_CMUL: ctrl.mul_car = 1'b1;
      fmtg_pkg::ST_OUT: begin
        // keep the amplitude product in place while the output is held
        ctrl.mul_car  = 1'b1;
        ctrl.out_load = out_free;
      end
      default:           ctrl = '0;
    endcase
  end

  `FMTG_ASSERT_IMP(a_live_item_reaches_out, in_valid && ctrl.in_ready && !run_done, ##6 (state == fmtg_pkg::ST_OUT), "live item did not reach output stage in 6 cycles")
  `FMTG_ASSERT_NXT(a_out_holds_when_full, state == fmtg_pkg::ST_OUT && !out_free, (state == fmtg_pkg::ST_OUT), "left output stage with register full")
  `FMTG_ASSERT_NXT(a_rom_not_back_to_back, ctrl.rom_en, (!ctrl.rom_en), "sine lookups in consecutive cycles")

endmodule

@@ hdl/fm_tone_generator.sv @@
// FM tone generator: one 16-bit sample per input beat within the run.
// Beats are taken only in idle, one sample at a time; output waits on a held beat.
// An item past the end of the run (no result) is absorbed while idle.
// Rate is set by the single shared 32x16 multiplier and the one sine table port,
// each used twice per sample. Reset restores register defaults and clears
// the counter and both phases; no clearing pass.
`timescale 1ns / 1ps
`include "fm_tone_generator_macros.svh"

module fm_tone_generator #(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned COUNT_BITS     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input beats
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero
  // result beats
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // [15:0] sample (signed)
  output logic                              m_tlast,   // final sample of the run
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fmtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  // ---------------- configuration registers ----------------
  logic [15:0] amplitude;
  logic [31:0] carrier_step;
  logic [31:0] mod_step;
  logic [31:0] mod_index;
  logic [31:0] run_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= '0;
      carrier_step <= '0;
      mod_step     <= 32'd1;
      mod_index    <= '0;
      run_length   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmtg_pkg::REG_AMPLITUDE:    amplitude    <= cfg_data[15:0];
        fmtg_pkg::REG_CARRIER_STEP: carrier_step <= cfg_data;
        fmtg_pkg::REG_MOD_STEP:     mod_step     <= cfg_data;
        fmtg_pkg::REG_MOD_INDEX:    mod_index    <= cfg_data;
        fmtg_pkg::REG_RUN_LENGTH:   run_length   <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- run state ----------------
  logic [COUNT_BITS-1:0] sample_index;
  logic [PHASE_BITS-1:0] carrier_phase;
  logic [PHASE_BITS-1:0] modulator_phase;
  logic [PHASE_BITS-1:0] phase_sum;     // carrier phase plus deviation

  logic [COUNT_BITS-1:0] count_lim;
  logic                  restart;
  logic                  run_done;
  logic                  in_beat;
  logic                  last_now;
  logic                  out_free;

  fmtg_pkg::ctrl_t ctrl;

  assign count_lim = COUNT_BITS'(run_length);
  assign restart   = s_tdata[0];
  assign in_beat   = s_tvalid && s_tready;
  assign s_tready  = ctrl.in_ready;
  assign out_free  = !m_tvalid || m_tready;
  assign last_now  = COUNT_BITS'(sample_index + 1'b1) == count_lim;

  // Run already finished (restart sees a zeroed counter).
  always_comb begin
    if (restart) begin
      run_done = (count_lim == '0);
    end else begin
      run_done = (sample_index >= count_lim);
    end
  end

  // Steps are in 2^32 units per turn: rescale to PHASE_BITS.
  logic [PHASE_BITS+fmtg_pkg::STEP_W-1:0] car_wide;
  logic [PHASE_BITS+fmtg_pkg::STEP_W-1:0] mod_wide;
  logic [PHASE_BITS-1:0]                  car_inc;
  logic [PHASE_BITS-1:0]                  mod_inc;

  assign car_wide = {carrier_step, {PHASE_BITS{1'b0}}};
  assign mod_wide = {mod_step, {PHASE_BITS{1'b0}}};
  assign car_inc  = car_wide[PHASE_BITS+fmtg_pkg::STEP_W-1:fmtg_pkg::STEP_W];
  assign mod_inc  = mod_wide[PHASE_BITS+fmtg_pkg::STEP_W-1:fmtg_pkg::STEP_W];

  // ---------------- shared sine table ----------------
  logic [PHASE_BITS-1:0]            rom_phase;
  logic [fmtg_pkg::MAG_W-1:0]       rom_mag;
  logic                             rom_neg;

  assign rom_phase = ctrl.rom_car ? phase_sum : modulator_phase;

  fmtg_sine_rom #(
    .PHASE_BITS (PHASE_BITS),
    .ADDR_BITS  (SINE_ADDR_BITS)
  ) u_rom (
    .clk   (clk),
    .en    (ctrl.rom_en),
    .phase (rom_phase),
    .mag   (rom_mag),
    .neg   (rom_neg)
  );

  // ---------------- shared multiplier ----------------
  // First pass: mod_index * |modulator sine|; second: amplitude * |carrier sine|.
  logic [fmtg_pkg::MUL_A_W-1:0] mul_a;
  logic [fmtg_pkg::MUL_B_W-1:0] mul_b;
  logic [fmtg_pkg::PROD_W-1:0]  prod;

  assign mul_a = ctrl.mul_car ? fmtg_pkg::MUL_A_W'(amplitude) : mod_index;
  assign mul_b = fmtg_pkg::MUL_B_W'(rom_mag);

  fmtg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Deviation in phase units: prod * 2^PHASE_BITS / 2^39, wrapped.
  logic [PHASE_BITS+fmtg_pkg::PROD_W-1:0] dev_wide;
  logic [PHASE_BITS-1:0]                  dev;

  assign dev_wide = {prod, {PHASE_BITS{1'b0}}};
  assign dev      = dev_wide[PHASE_BITS+fmtg_pkg::DEV_SHIFT-1:fmtg_pkg::DEV_SHIFT];

  always_ff @(posedge clk) begin
    if (ctrl.sum_load) begin
      // rom_neg still holds the modulator sign here
      phase_sum <= rom_neg ? carrier_phase - dev : carrier_phase + dev;
    end
  end

  // ---------------- round half away from zero, clamp ----------------
  logic [16:0]        rmag;
  logic signed [15:0] sample_next;

  assign rmag = 17'((prod[31:0] + 32'd16384) >> 15);

  always_comb begin
    if (rom_neg) begin
      sample_next = (rmag > 17'd32768) ? 16'sh8000 : $signed(16'(17'd0 - rmag));
    end else begin
      sample_next = (rmag > 17'd32767) ? 16'sh7fff : $signed(rmag[15:0]);
    end
  end

  // ---------------- counter and phase accumulators ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      carrier_phase   <= '0;
      modulator_phase <= '0;
    end else if (in_beat && restart) begin
      sample_index    <= '0;
      carrier_phase   <= '0;
      modulator_phase <= '0;
    end else if (ctrl.out_load) begin
      sample_index    <= COUNT_BITS'(sample_index + 1'b1);
      carrier_phase   <= carrier_phase + car_inc;
      modulator_phase <= modulator_phase + mod_inc;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= sample_next;
      m_tlast <= last_now;
    end
  end

  // ---------------- sequencer ----------------
  fmtg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .run_done (run_done),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  `FMTG_ASSERT_IMP(a_load_into_free_reg, ctrl.out_load, (!m_tvalid || m_tready), "output register overwritten")
  `FMTG_ASSERT_NXT(a_last_ends_run, ctrl.out_load && last_now, (sample_index == count_lim), "counter not at count after final sample")
  `FMTG_ASSERT_NXT(a_beat_held, m_tvalid && !m_tready, (m_tvalid && $stable(m_tdata)), "stalled beat changed")

endmodule
